### sv/bcas_pkg.sv
package bcas_pkg;

  localparam logic [15:0] FAST_CTL0   = 16'h09F0;
  localparam logic [15:0] MERGE_CTL0  = 16'h07CA;
  localparam logic [15:0] REVERSE_BIT = 16'h0002;
  localparam logic [15:0] FULL_MASK   = 16'hFFFF;

  // One copy request as it arrives on the input channel.
  typedef struct packed {
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [10:0] source_x;
    logic [10:0] source_y;
    logic [9:0]  area_width;
    logic [10:0] area_height;
    logic [11:0] source_row_bytes;
    logic [11:0] dest_row_bytes;
    logic [31:0] source_plane_base;
    logic [31:0] dest_plane_base;
  } req_t;

  // Descriptor words that are final after decode and only ride along.
  typedef struct packed {
    logic [15:0] size_word;
    logic [15:0] control_zero;
    logic [15:0] control_one;
    logic [15:0] first_mask;
    logic [15:0] last_mask;
    logic [15:0] source_modulo;
    logic [15:0] dest_modulo;
    logic        fast_path;
    logic        reverse_mode;
  } desc_t;

  // Decode stage result: row indexes and byte adjustments for the pointers.
  typedef struct packed {
    desc_t              desc;
    logic [31:0]        sbase;
    logic [31:0]        dbase;
    logic signed [12:0] srow;
    logic signed [12:0] drow;
    logic [11:0]        srb;
    logic [11:0]        drb;
    logic [8:0]         sadd;
    logic [8:0]         dadd;
  } dec_t;

  // Offset stage result: signed row offsets from the multipliers.
  typedef struct packed {
    desc_t              desc;
    logic [31:0]        sbase;
    logic [31:0]        dbase;
    logic signed [25:0] soff;
    logic signed [25:0] doff;
    logic [8:0]         sadd;
    logic [8:0]         dadd;
  } off_t;

  // Final descriptor as presented on the output channel.
  typedef struct packed {
    desc_t       desc;
    logic [31:0] source_pointer;
    logic [31:0] dest_pointer;
  } res_t;

endpackage

### sv/bcas_decode.sv
module bcas_decode (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bcas_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output bcas_pkg::dec_t out_dec
);
  import bcas_pkg::*;

  logic        valid_r;
  dec_t        stage_r;
  dec_t        stage_nxt;
  logic        advance;

  logic [3:0]  dfine;
  logic [3:0]  sfine;
  logic        fwd;
  logic [3:0]  shift;
  logic [10:0] span;
  logic [10:0] rnd;
  logic [3:0]  tail;
  logic [7:0]  rowb;
  logic [15:0] fmask;
  logic [15:0] lmask;
  logic        fast;
  logic [7:0]  sstart;
  logic [7:0]  dstart;
  logic [12:0] srow_u;
  logic [12:0] drow_u;

  assign advance  = !valid_r || !out_stall;
  assign in_stall = !advance;

  always_comb begin
    dfine  = in_req.dest_x[3:0];
    sfine  = in_req.source_x[3:0];
    fwd    = (dfine >= sfine);
    shift  = fwd ? dfine : sfine;
    span   = {7'd0, shift} + {1'b0, in_req.area_width};
    rnd    = span + 11'd15;
    tail   = span[3:0];
    rowb   = {rnd[10:4], 1'b0};
    fmask  = FULL_MASK >> dfine;
    lmask  = (tail == 4'd0) ? FULL_MASK : ~(FULL_MASK >> tail);
    fast   = (shift == 4'd0) && (tail == 4'd0);
    sstart = {in_req.source_x[10:4], 1'b0};
    dstart = {in_req.dest_x[10:4], 1'b0};

    // Reverse starts on the last row: y + height - 1 (may reach -1).
    srow_u = {2'b00, in_req.source_y};
    drow_u = {2'b00, in_req.dest_y};
    if (!fwd) begin
      srow_u = srow_u + {2'b00, in_req.area_height} - 13'd1;
      drow_u = drow_u + {2'b00, in_req.area_height} - 13'd1;
    end

    stage_nxt.srow  = $signed(srow_u);
    stage_nxt.drow  = $signed(drow_u);
    stage_nxt.srb   = in_req.source_row_bytes;
    stage_nxt.drb   = in_req.dest_row_bytes;
    stage_nxt.sbase = in_req.source_plane_base;
    stage_nxt.dbase = in_req.dest_plane_base;
    // Reverse starts at the last word of the row; rowb >= 2 there.
    stage_nxt.sadd  = fwd ? {1'b0, sstart} : ({1'b0, sstart} + {1'b0, rowb} - 9'd2);
    stage_nxt.dadd  = fwd ? {1'b0, dstart} : ({1'b0, dstart} + {1'b0, rowb} - 9'd2);

    stage_nxt.desc.size_word     = {in_req.area_height[9:0], 6'd0} | {9'd0, rowb[7:1]};
    stage_nxt.desc.source_modulo = {4'd0, in_req.source_row_bytes} - {8'd0, rowb};
    stage_nxt.desc.dest_modulo   = {4'd0, in_req.dest_row_bytes} - {8'd0, rowb};
    stage_nxt.desc.fast_path     = fast;
    stage_nxt.desc.reverse_mode  = !fwd;
    if (fast) begin
      stage_nxt.desc.control_zero = FAST_CTL0;
      stage_nxt.desc.control_one  = 16'd0;
      stage_nxt.desc.first_mask   = FULL_MASK;
      stage_nxt.desc.last_mask    = FULL_MASK;
    end else begin
      stage_nxt.desc.control_zero = MERGE_CTL0;
      stage_nxt.desc.control_one  = {shift, 12'd0} | (fwd ? 16'd0 : REVERSE_BIT);
      stage_nxt.desc.first_mask   = fwd ? fmask : lmask;
      stage_nxt.desc.last_mask    = fwd ? lmask : fmask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_dec   = stage_r;

endmodule

### sv/bcas_offset.sv
module bcas_offset (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bcas_pkg::dec_t in_dec,
  output logic           out_valid,
  input  logic           out_stall,
  output bcas_pkg::off_t out_off
);
  import bcas_pkg::*;

  logic valid_r;
  off_t stage_r;
  off_t stage_nxt;
  logic advance;

  assign advance  = !valid_r || !out_stall;
  assign in_stall = !advance;

  // Row index times row bytes, signed 13 x 13 bits.
  always_comb begin
    stage_nxt.desc  = in_dec.desc;
    stage_nxt.sbase = in_dec.sbase;
    stage_nxt.dbase = in_dec.dbase;
    stage_nxt.sadd  = in_dec.sadd;
    stage_nxt.dadd  = in_dec.dadd;
    stage_nxt.soff  = in_dec.srow * $signed({1'b0, in_dec.srb});
    stage_nxt.doff  = in_dec.drow * $signed({1'b0, in_dec.drb});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_off   = stage_r;

endmodule

### sv/bcas_addr.sv
module bcas_addr (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bcas_pkg::off_t in_off,
  output logic           out_valid,
  input  logic           out_stall,
  output bcas_pkg::res_t out_res
);
  import bcas_pkg::*;

  logic valid_r;
  res_t stage_r;
  res_t stage_nxt;
  logic advance;

  assign advance  = !valid_r || !out_stall;
  assign in_stall = !advance;

  // Base plus sign-extended row offset plus column bytes, wrap at 32 bits.
  always_comb begin
    stage_nxt.desc           = in_off.desc;
    stage_nxt.source_pointer = in_off.sbase + {{6{in_off.soff[25]}}, in_off.soff}
                               + {23'd0, in_off.sadd};
    stage_nxt.dest_pointer   = in_off.dbase + {{6{in_off.doff[25]}}, in_off.doff}
                               + {23'd0, in_off.dadd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = stage_r;

endmodule

### sv/blit_copy_area_setup_unit.sv
// Path: an accepted request passes the decode, offset and address stage registers;
// the address stage register drives out_ and holds while out_stall is high.
// Throughput: one request per cycle unless stalled; the three stages hold one request each.
// Stages: decode, row-offset multiply, pointer add; out_stall backs up stage by stage.
// Reset: synchronous, active-low rst_n empties all stages; no other state.
module blit_copy_area_setup_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] in_dest_x,
  input  logic [10:0] in_dest_y,
  input  logic [10:0] in_source_x,
  input  logic [10:0] in_source_y,
  input  logic [9:0]  in_area_width,
  input  logic [10:0] in_area_height,
  input  logic [11:0] in_source_row_bytes,
  input  logic [11:0] in_dest_row_bytes,
  input  logic [31:0] in_source_plane_base,
  input  logic [31:0] in_dest_plane_base,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_source_pointer,
  output logic [31:0] out_dest_pointer,
  output logic [15:0] out_size_word,
  output logic [15:0] out_control_zero,
  output logic [15:0] out_control_one,
  output logic [15:0] out_first_mask,
  output logic [15:0] out_last_mask,
  output logic [15:0] out_source_modulo,
  output logic [15:0] out_dest_modulo,
  output logic        out_fast_path,
  output logic        out_reverse_mode
);
  import bcas_pkg::*;

  req_t req;
  dec_t dec;
  off_t off;
  res_t res;

  logic dec_valid;
  logic dec_stall;
  logic off_valid;
  logic off_stall;

  // Gather the request fields into one word for the decode stage.
  always_comb begin
    req.dest_x            = in_dest_x;
    req.dest_y            = in_dest_y;
    req.source_x          = in_source_x;
    req.source_y          = in_source_y;
    req.area_width        = in_area_width;
    req.area_height       = in_area_height;
    req.source_row_bytes  = in_source_row_bytes;
    req.dest_row_bytes    = in_dest_row_bytes;
    req.source_plane_base = in_source_plane_base;
    req.dest_plane_base   = in_dest_plane_base;
  end

  // Stage one: pick direction and shift, build masks, size, modulos, controls.
  bcas_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (req),
    .out_valid (dec_valid),
    .out_stall (dec_stall),
    .out_dec   (dec)
  );

  // Stage two: row index times row bytes for both bitmaps.
  bcas_offset u_offset (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_stall  (dec_stall),
    .in_dec    (dec),
    .out_valid (off_valid),
    .out_stall (off_stall),
    .out_off   (off)
  );

  // Stage three: add plane base, row offset and column bytes; hold for output.
  bcas_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (off_valid),
    .in_stall  (off_stall),
    .in_off    (off),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Drive the result ports from the last stage register.
  assign out_source_pointer = res.source_pointer;
  assign out_dest_pointer   = res.dest_pointer;
  assign out_size_word      = res.desc.size_word;
  assign out_control_zero   = res.desc.control_zero;
  assign out_control_one    = res.desc.control_one;
  assign out_first_mask     = res.desc.first_mask;
  assign out_last_mask      = res.desc.last_mask;
  assign out_source_modulo  = res.desc.source_modulo;
  assign out_dest_modulo    = res.desc.dest_modulo;
  assign out_fast_path      = res.desc.fast_path;
  assign out_reverse_mode   = res.desc.reverse_mode;

  // Input stalls only when every stage is full behind a stalled output.
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && dec_valid && off_valid))
    else $error("input stalled while a stage is empty");

  // Fast path is always forward with the plain copy control word.
  a_fast_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fast_path) |->
      (!out_reverse_mode && out_control_zero == FAST_CTL0 && out_control_one == 16'd0))
    else $error("fast path descriptor inconsistent");

  // Merge path carries the reverse flag in control_one.
  a_merge_rev : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fast_path) |->
      (out_control_one[1] == out_reverse_mode && out_control_zero == MERGE_CTL0))
    else $error("merge path reverse flag mismatch");

  // Reverse only happens when the source fine offset is larger, so shift is nonzero.
  a_rev_shift : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reverse_mode) |-> (out_control_one[15:12] != 4'd0))
    else $error("reverse request with zero shift");

endmodule
